// ===== rtl/dcs_pkg.sv =====
// Package for the difference constraint store: constants and codes.
`timescale 1ns / 1ps
`default_nettype none
package dcs_pkg;
  localparam int STEP_LIMIT_DEF     = 64;
  localparam int VARIABLE_LIMIT_DEF = 32;
  localparam int PLACE_BITS_DEF     = 16;

  localparam logic [1:0] OP_LEARN  = 2'd0;
  localparam logic [1:0] OP_FORGET = 2'd1;
  localparam logic [1:0] OP_ASSIGN = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [2:0] REL_LT = 3'd0;
  localparam logic [2:0] REL_LE = 3'd1;
  localparam logic [2:0] REL_EQ = 3'd2;
  localparam logic [2:0] REL_GE = 3'd3;
  localparam logic [2:0] REL_GT = 3'd4;

  localparam logic signed [63:0] INT64_MIN = {1'b1, 63'd0};
  localparam logic signed [63:0] ONE64     = 64'sd1;
endpackage
`default_nettype wire

// ===== rtl/difference_constraint_store_unit.sv =====
// Top level of the difference constraint store with a Bellman-Ford bound query.
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Handshake                      | Word
// s_axis  | in  | s_axis_tvalid / s_axis_tready  | tdata, tuser (operation)
// m_axis  | out | m_axis_tvalid / m_axis_tready  | tdata (result)
// One word in flight at a time; each table entry and scratch entry the sequencer visits
// is read through a register (memories have one registered read port).
// Learn/assign: each constrain scans and shifts the table; from VARIABLE_LIMIT/2
// entries up, a distinct-term count over the table is added. Forget: one table pass.
// Query: up to STEP_LIMIT edge visits, each with two scans of up to VARIABLE_LIMIT+2
// scratch terms.
// Synchronous reset clears counts and the flag; no clearing pass is needed.
// A held result blocks the next word until the output side takes it.
module difference_constraint_store_unit #(
  parameter int STEP_LIMIT     = dcs_pkg::STEP_LIMIT_DEF,
  parameter int VARIABLE_LIMIT = dcs_pkg::VARIABLE_LIMIT_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: first_term[16], first_is_zero, second_term[16], second_is_zero,
  // relation[3], amount[64], zero fill to 104 bits
  input  wire [103:0] s_axis_tdata,
  // tuser: operation[2]
  input  wire [1:0]   s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata from bit 0: bound_found, bound_value[64], implied, out_of_budget, zero fill
  output logic [71:0] m_axis_tdata
);
  localparam int PLACE_BITS = dcs_pkg::PLACE_BITS_DEF;
  localparam int TW  = PLACE_BITS + 1;
  localparam int EW  = $clog2(STEP_LIMIT);
  localparam int CW  = $clog2(STEP_LIMIT + 1);
  localparam int DD  = VARIABLE_LIMIT + 2;
  localparam int DW  = $clog2(DD);
  localparam int DCW = $clog2(DD + 1);
  localparam int VW  = $clog2(2 * STEP_LIMIT + 3);
  localparam int WW  = $clog2(STEP_LIMIT + 2);
  localparam int RW  = $clog2(VARIABLE_LIMIT + 3);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_C_SCAN, S_C_CHK, S_C_VAR_X, S_C_VAR_Y, S_C_VAR_SCAN,
    S_C_VAR_CHK, S_C_SHIFT, S_C_SHIFT_W, S_C_DONE, S_FG_RD, S_FG_W, S_SA_RD, S_SA_W,
    S_Q_EDGE, S_Q_EDGE_W, S_Q_FROM, S_Q_TO, S_Q_UPD, S_Q_ROUND, S_Q_FIND, S_OUT
  } state_t;

  // table and scratch memories
  logic [TW-1:0]        ent_f [STEP_LIMIT];
  logic [TW-1:0]        ent_s [STEP_LIMIT];
  logic signed [63:0]   ent_l [STEP_LIMIT];
  logic [TW-1:0]        dst_t [DD];
  logic signed [63:0]   dst_v [DD];
  logic [TW-1:0]        var_t [2*STEP_LIMIT+2];

  state_t state;
  logic [CW-1:0] count;
  logic exhausted;
  logic [1:0] op;
  logic [2:0] rel;
  logic [TW-1:0] fa, fb, qx, cx, cy;
  logic signed [63:0] amt, cb;
  logic [CW-1:0] idx, wk, pos;
  logic [1:0] phase;          // which constrain call is running
  logic rd_f_ok;
  logic [TW-1:0] rf, rs;
  logic signed [63:0] rl;
  logic [DCW-1:0] dcount, di;
  logic [TW-1:0] dt_rd;
  logic signed [63:0] dv_rd;
  logic [VW-1:0] vn, vi;
  logic [TW-1:0] vt_rd, vcand;
  logic [1:0] vsrc;           // 0 entry first, 1 entry second during var scan
  logic known_x, known_y;
  logic [WW-1:0] work;
  logic [RW-1:0] round;
  logic changed;
  logic signed [63:0] dfrom, cand;
  logic found_q;
  logic signed [63:0] bval;

  // shared adder: a + (b ^ inv) + inv, overflow from signs
  logic signed [63:0] add_a, add_b, add_r;
  logic add_sub, add_ov;
  always_comb begin
    logic signed [63:0] bb;
    bb = add_sub ? ~add_b : add_b;
    add_r = add_a + bb + {63'd0, add_sub};
    add_ov = (add_a[63] == bb[63]) && (add_r[63] != add_a[63]);
  end

  // key compare of read entry against (cx, cy)
  logic key_lt, key_eq;
  always_comb begin
    key_eq = (rf == cx) && (rs == cy);
    key_lt = (rf < cx) || ((rf == cx) && (rs < cy));
  end

  logic [TW-1:0] in_f, in_s;
  always_comb begin
    in_f = {1'b0, s_axis_tdata[PLACE_BITS-1:0]} + TW'(1);
    in_s = {1'b0, s_axis_tdata[17 +: PLACE_BITS]} + TW'(1);
  end

  assign s_axis_tready = (state == S_IDLE);

  // adder operand selection per state
  always_comb begin
    add_a = amt; add_b = dcs_pkg::ONE64; add_sub = 1'b1;
    case (state)
      S_DISPATCH: begin add_a = amt; add_b = dcs_pkg::ONE64; add_sub = 1'b1; end
      S_C_DONE: begin
        if (phase == 2'd2) begin add_a = cb; add_b = dcs_pkg::ONE64; end
        else begin add_a = 64'sd0; add_b = amt; end
        add_sub = 1'b1;
      end
      S_SA_W: begin add_a = rl; add_b = amt; add_sub = (rs == fa) && (rf != fa); end
      S_Q_TO: begin add_a = dfrom; add_b = rl; add_sub = 1'b0; end
      default: begin add_a = cb; add_b = dcs_pkg::ONE64; add_sub = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      exhausted <= 1'b0;
      dcount <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          op <= s_axis_tuser;
          rel <= s_axis_tdata[36:34];
          amt <= s_axis_tdata[100:37];
          fa <= in_f;
          // learn always takes the second place; others honor the zero flag
          fb <= (s_axis_tdata[33] && (s_axis_tuser != dcs_pkg::OP_LEARN)) ? '0 : in_s;
          qx <= s_axis_tdata[16] ? '0 : in_f;
          cx <= in_f; cy <= in_s;
          idx <= '0; wk <= '0; phase <= 2'd0; found_q <= 1'b0; bval <= '0;
          state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          case (op)
            dcs_pkg::OP_LEARN: begin
              cx <= fa; cy <= fb; phase <= 2'd0; idx <= '0;
              cb <= (rel == dcs_pkg::REL_LT) ? add_r : amt;
              if (rel == dcs_pkg::REL_LT && add_ov) state <= S_OUT;
              else if (rel <= dcs_pkg::REL_EQ) state <= S_C_SCAN;
              else if (rel <= dcs_pkg::REL_GT) state <= S_C_DONE;
              else state <= S_OUT;
            end
            dcs_pkg::OP_FORGET: begin idx <= '0; wk <= '0; state <= S_FG_RD; end
            dcs_pkg::OP_ASSIGN: begin
              idx <= '0; wk <= '0;
              state <= (fb == fa) ? S_SA_RD : S_FG_RD;
            end
            default: begin
              dst_t[0] <= fb; dst_v[0] <= '0; dcount <= DCW'(1);
              work <= '0; round <= '0; changed <= 1'b0; idx <= '0;
              state <= S_Q_EDGE;
            end
          endcase
        end
        // constrain: find insert position
        S_C_SCAN: begin
          if (idx == count) begin pos <= idx; state <= S_C_CHK; rd_f_ok <= 1'b0; end
          else begin
            rf <= ent_f[idx[EW-1:0]]; rs <= ent_s[idx[EW-1:0]]; rl <= ent_l[idx[EW-1:0]];
            rd_f_ok <= 1'b1; state <= S_C_CHK;
          end
        end
        S_C_CHK: begin
          if (rd_f_ok && key_lt) begin idx <= idx + CW'(1); state <= S_C_SCAN; end
          else if (rd_f_ok && key_eq) begin
            if (rl > cb) ent_l[idx[EW-1:0]] <= cb;
            state <= S_C_DONE;
          end else begin
            pos <= idx;
            if (count >= CW'(STEP_LIMIT)) begin exhausted <= 1'b1; state <= S_C_DONE; end
            else if (count >= CW'(VARIABLE_LIMIT / 2)) begin
              known_x <= (cx == '0); known_y <= (cy == '0);
              vi <= '0; vn <= '0; vsrc <= 2'd0; wk <= '0;
              state <= S_C_VAR_X;
            end else begin wk <= count; state <= S_C_SHIFT; end
          end
        end
        // distinct-variable count: scan entries, collecting terms in var_t
        S_C_VAR_X: begin
          vcand <= cx; vi <= '0; vt_rd <= var_t[0]; vsrc <= 2'd2; state <= S_C_VAR_CHK;
        end
        S_C_VAR_Y: begin
          vcand <= cy; vi <= '0; vt_rd <= var_t[0]; vsrc <= 2'd3; state <= S_C_VAR_CHK;
        end
        S_C_VAR_SCAN: begin
          if (wk == count) begin
            if ((known_x && known_y) || (vn <= VW'(VARIABLE_LIMIT))) begin
              wk <= count; state <= S_C_SHIFT;
            end else begin exhausted <= 1'b1; state <= S_C_DONE; end
          end else begin
            vcand <= vsrc[0] ? ent_s[wk[EW-1:0]] : ent_f[wk[EW-1:0]];
            vi <= '0; vt_rd <= var_t[0]; state <= S_C_VAR_CHK;
          end
        end
        S_C_VAR_CHK: begin
          if (vcand == '0 || (vi != vn && vt_rd == vcand)) begin
            if (vsrc[1] == 1'b0) begin
              if (vcand == cx) known_x <= 1'b1;
              if (vcand == cy) known_y <= 1'b1;
            end
            if (vsrc == 2'd2) state <= S_C_VAR_Y;
            else if (vsrc == 2'd3) begin vsrc <= 2'd0; wk <= '0; state <= S_C_VAR_SCAN; end
            else if (vsrc == 2'd0) begin vsrc <= 2'd1; state <= S_C_VAR_SCAN; end
            else begin vsrc <= 2'd0; wk <= wk + CW'(1); state <= S_C_VAR_SCAN; end
          end else if (vi == vn) begin
            var_t[vi] <= vcand; vn <= vn + VW'(1);
            if (vsrc[1] == 1'b0) begin
              if (vcand == cx) known_x <= 1'b1;
              if (vcand == cy) known_y <= 1'b1;
            end
            if (vsrc == 2'd2) state <= S_C_VAR_Y;
            else if (vsrc == 2'd3) begin vsrc <= 2'd0; wk <= '0; state <= S_C_VAR_SCAN; end
            else if (vsrc == 2'd0) begin vsrc <= 2'd1; state <= S_C_VAR_SCAN; end
            else begin vsrc <= 2'd0; wk <= wk + CW'(1); state <= S_C_VAR_SCAN; end
          end else begin
            vi <= vi + VW'(1); vt_rd <= var_t[vi + VW'(1)];
          end
        end
        // shift tail up by one, from the top down
        S_C_SHIFT: begin
          if (wk == pos) begin
            ent_f[pos[EW-1:0]] <= cx; ent_s[pos[EW-1:0]] <= cy; ent_l[pos[EW-1:0]] <= cb;
            count <= count + CW'(1); state <= S_C_DONE;
          end else begin
            rf <= ent_f[wk[EW-1:0] - EW'(1)]; rs <= ent_s[wk[EW-1:0] - EW'(1)];
            rl <= ent_l[wk[EW-1:0] - EW'(1)]; state <= S_C_SHIFT_W;
          end
        end
        S_C_SHIFT_W: begin
          ent_f[wk[EW-1:0]] <= rf; ent_s[wk[EW-1:0]] <= rs; ent_l[wk[EW-1:0]] <= rl;
          wk <= wk - CW'(1); state <= S_C_SHIFT;
        end
        // after a constrain: start the reversed one if any
        S_C_DONE: begin
          idx <= '0;
          if (phase == 2'd0) begin
            if (op == dcs_pkg::OP_LEARN) begin
              cx <= fb; cy <= fa;
              if (add_ov || rel < dcs_pkg::REL_EQ || rel > dcs_pkg::REL_GT) begin
                phase <= 2'd1; state <= S_OUT;
              end else if (rel == dcs_pkg::REL_GT) begin
                cb <= add_r; phase <= 2'd2; state <= S_C_DONE;
              end else begin cb <= add_r; phase <= 2'd1; state <= S_C_SCAN; end
            end else begin
              phase <= 2'd1;
              cx <= fb; cy <= fa; cb <= add_r;
              state <= (amt == dcs_pkg::INT64_MIN) ? S_OUT : S_C_SCAN;
            end
          end else if (phase == 2'd2) begin
            // greater: reversed limit is one below the negated offset
            phase <= 2'd1;
            if (add_ov) state <= S_OUT;
            else begin cb <= add_r; state <= S_C_SCAN; end
          end else state <= S_OUT;
        end
        // forget: compact, dropping entries touching fa
        S_FG_RD: begin
          if (idx == count) begin
            count <= wk;
            if (op == dcs_pkg::OP_ASSIGN) begin
              cx <= fa; cy <= fb; cb <= amt; phase <= 2'd0; idx <= '0; state <= S_C_SCAN;
            end else state <= S_OUT;
          end else begin
            rf <= ent_f[idx[EW-1:0]]; rs <= ent_s[idx[EW-1:0]]; rl <= ent_l[idx[EW-1:0]];
            state <= S_FG_W;
          end
        end
        S_FG_W: begin
          if (rf != fa && rs != fa) begin
            ent_f[wk[EW-1:0]] <= rf; ent_s[wk[EW-1:0]] <= rs; ent_l[wk[EW-1:0]] <= rl;
            wk <= wk + CW'(1);
          end
          idx <= idx + CW'(1); state <= S_FG_RD;
        end
        // self assignment: shift limits, dropping overflows
        S_SA_RD: begin
          if (idx == count) begin count <= wk; state <= S_OUT; end
          else begin
            rf <= ent_f[idx[EW-1:0]]; rs <= ent_s[idx[EW-1:0]]; rl <= ent_l[idx[EW-1:0]];
            state <= S_SA_W;
          end
        end
        S_SA_W: begin
          if (rf == rs || (rf != fa && rs != fa) || !add_ov) begin
            ent_f[wk[EW-1:0]] <= rf; ent_s[wk[EW-1:0]] <= rs;
            ent_l[wk[EW-1:0]] <= (rf == rs || (rf != fa && rs != fa)) ? rl : add_r;
            wk <= wk + CW'(1);
          end
          idx <= idx + CW'(1); state <= S_SA_RD;
        end
        // query: one edge per pass
        S_Q_EDGE: begin
          if (idx == count) state <= S_Q_ROUND;
          else if (work == WW'(STEP_LIMIT)) begin exhausted <= 1'b1; state <= S_OUT; end
          else begin
            work <= work + WW'(1);
            rf <= ent_f[idx[EW-1:0]]; rs <= ent_s[idx[EW-1:0]]; rl <= ent_l[idx[EW-1:0]];
            di <= '0; state <= S_Q_EDGE_W;
          end
        end
        S_Q_EDGE_W: begin
          dt_rd <= dst_t[di[DW-1:0]]; dv_rd <= dst_v[di[DW-1:0]];
          state <= S_Q_FROM;
        end
        S_Q_FROM: begin
          if (di == dcount) begin idx <= idx + CW'(1); state <= S_Q_EDGE; end
          else if (dt_rd == rs) begin dfrom <= dv_rd; state <= S_Q_TO; end
          else begin di <= di + DCW'(1); state <= S_Q_EDGE_W; end
        end
        S_Q_TO: begin
          if (add_ov) state <= S_OUT;
          else begin cand <= add_r; di <= '0; state <= S_Q_UPD; end
          dt_rd <= dst_t[0]; dv_rd <= dst_v[0];
        end
        S_Q_UPD: begin
          if (di == dcount) begin
            if (dcount >= DCW'(DD)) begin exhausted <= 1'b1; state <= S_OUT; end
            else begin
              dst_t[dcount[DW-1:0]] <= rf; dst_v[dcount[DW-1:0]] <= cand;
              dcount <= dcount + DCW'(1); changed <= 1'b1;
              idx <= idx + CW'(1); state <= S_Q_EDGE;
            end
          end else if (dt_rd == rf) begin
            if (cand < dv_rd) begin dst_v[di[DW-1:0]] <= cand; changed <= 1'b1; end
            idx <= idx + CW'(1); state <= S_Q_EDGE;
          end else begin
            di <= di + DCW'(1);
            if (di + DCW'(1) != dcount) begin
              dt_rd <= dst_t[di[DW-1:0] + DW'(1)]; dv_rd <= dst_v[di[DW-1:0] + DW'(1)];
            end
          end
        end
        S_Q_ROUND: begin
          idx <= '0; changed <= 1'b0;
          if (!changed) begin
            di <= '0; dt_rd <= dst_t[0]; dv_rd <= dst_v[0]; state <= S_Q_FIND;
          end else if (round == RW'(VARIABLE_LIMIT + 1)) state <= S_OUT;
          else begin round <= round + RW'(1); state <= S_Q_EDGE; end
        end
        S_Q_FIND: begin
          if (di == dcount) state <= S_OUT;
          else if (dt_rd == qx) begin found_q <= 1'b1; bval <= dv_rd; state <= S_OUT; end
          else begin
            di <= di + DCW'(1);
            if (di + DCW'(1) != dcount) begin
              dt_rd <= dst_t[di[DW-1:0] + DW'(1)]; dv_rd <= dst_v[di[DW-1:0] + DW'(1)];
            end
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {5'd0, exhausted, found_q && (bval <= amt), bval, found_q};
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
